// ----- sv/compass_heading_with_limits_assert.svh -----
// Assertion macros shared by the compass heading block
`ifndef COMPASS_HEADING_WITH_LIMITS_ASSERT_SVH
`define COMPASS_HEADING_WITH_LIMITS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define CHWL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CHWL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/chwl_pkg.sv -----
// Types and constants of the compass heading block
package chwl_pkg;

	// widest sample the block supports; queue entries carry samples at this width
	localparam int SAMPLE_MAX_BITS = 16;

	// CORDIC datapath: samples are scaled by 2^24, plus headroom for gain and sign
	localparam int PRESCALE_SH = 24;
	localparam int CORDIC_GUARD = 26;

	// angle accumulator, degrees times 2^16
	localparam int ANG_W = 27;
	localparam int ATAN_ENTRIES = 24;
	localparam int ATAN_IDX_W = 5;
	localparam int ATAN_W = 22;

	localparam logic [ATAN_W-1:0] ATAN_Q16 [ATAN_ENTRIES] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
		22'd234379, 22'd117304, 22'd58666, 22'd29335,
		22'd14668, 22'd7334, 22'd3667, 22'd1833,
		22'd917, 22'd458, 22'd229, 22'd115,
		22'd57, 22'd29, 22'd14, 22'd7,
		22'd4, 22'd2, 22'd1, 22'd0
	};

	localparam logic signed [ANG_W-1:0] DEG180 = 27'sd11796480;
	localparam logic signed [ANG_W-1:0] DEG360 = 27'sd23592960;

	// degrees times 2^16 to degrees times 2^6, round half up
	localparam logic [ANG_W-1:0] ROUND_HALF = 27'd512;
	localparam int ROUND_SH = 10;

	localparam int HEADING_W = 15;
	localparam logic [HEADING_W:0] HEADING_FULL = 16'd23040;

	localparam int MIN_W = 13;
	localparam int MAX_W = 12;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// one classified sample waiting for the CORDIC engine
	typedef struct packed {
		logic signed [SAMPLE_MAX_BITS-1:0] x;
		logic signed [SAMPLE_MAX_BITS-1:0] y;
		logic                              zero;
		logic                              neg;
		logic signed [MIN_W-1:0]           x_min;
		logic        [MAX_W-1:0]           x_max;
		logic signed [MIN_W-1:0]           y_min;
		logic        [MAX_W-1:0]           y_max;
		logic signed [MIN_W-1:0]           z_min;
		logic        [MAX_W-1:0]           z_max;
	} job_t;

endpackage

// ----- sv/chwl_if.sv -----
// Valid/ready channel interfaces for samples and results

interface chwl_sample_if #(
	parameter int SAMPLE_BITS = 13
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] x_sample;
	logic signed [SAMPLE_BITS-1:0] y_sample;
	logic signed [SAMPLE_BITS-1:0] z_sample;

	modport source(output valid, x_sample, y_sample, z_sample, input ready);
	modport sink(input valid, x_sample, y_sample, z_sample, output ready);
endinterface

interface chwl_result_if;
	logic                                     valid;
	logic                                     ready;
	logic        [chwl_pkg::HEADING_W-1:0]    heading_q6;
	logic signed [chwl_pkg::MIN_W-1:0]        x_min_out;
	logic        [chwl_pkg::MAX_W-1:0]        x_max_out;
	logic signed [chwl_pkg::MIN_W-1:0]        y_min_out;
	logic        [chwl_pkg::MAX_W-1:0]        y_max_out;
	logic signed [chwl_pkg::MIN_W-1:0]        z_min_out;
	logic        [chwl_pkg::MAX_W-1:0]        z_max_out;

	modport source(output valid, heading_q6, x_min_out, x_max_out, y_min_out, y_max_out,
		z_min_out, z_max_out, input ready);
	modport sink(input valid, heading_q6, x_min_out, x_max_out, y_min_out, y_max_out,
		z_min_out, z_max_out, output ready);
endinterface

// ----- sv/chwl_front.sv -----
// Front end: accepts samples, tracks axis bounds, classifies for the CORDIC engine
`include "compass_heading_with_limits_assert.svh"

module chwl_front #(
	parameter int SAMPLE_BITS = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	chwl_sample_if.sink         sample,
	input  logic                full,
	output logic                push,
	output chwl_pkg::job_t      job
);

	logic signed [SAMPLE_BITS-1:0] xv, yv, zv;
	logic signed [SAMPLE_BITS-1:0] x_low_q, x_high_q, y_low_q, y_high_q, z_low_q, z_high_q;
	logic signed [SAMPLE_BITS-1:0] x_lo_n, x_hi_n, y_lo_n, y_hi_n, z_lo_n, z_hi_n;

	assign xv = sample.x_sample;
	assign yv = sample.y_sample;
	assign zv = sample.z_sample;

	assign sample.ready = !full;
	assign push = sample.valid && !full;

	always_comb begin
		x_lo_n = (xv < x_low_q)  ? xv : x_low_q;
		x_hi_n = (xv > x_high_q) ? xv : x_high_q;
		y_lo_n = (yv < y_low_q)  ? yv : y_low_q;
		y_hi_n = (yv > y_high_q) ? yv : y_high_q;
		z_lo_n = (zv < z_low_q)  ? zv : z_low_q;
		z_hi_n = (zv > z_high_q) ? zv : z_high_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q  <= '0;
			x_high_q <= '0;
			y_low_q  <= '0;
			y_high_q <= '0;
			z_low_q  <= '0;
			z_high_q <= '0;
		end else if (push) begin
			x_low_q  <= x_lo_n;
			x_high_q <= x_hi_n;
			y_low_q  <= y_lo_n;
			y_high_q <= y_hi_n;
			z_low_q  <= z_lo_n;
			z_high_q <= z_hi_n;
		end
	end

	// the job carries the bounds as they stand after this transaction
	always_comb begin
		job.x     = chwl_pkg::SAMPLE_MAX_BITS'(xv);
		job.y     = chwl_pkg::SAMPLE_MAX_BITS'(yv);
		job.zero  = (xv == '0) && (yv == '0);
		job.neg   = xv[SAMPLE_BITS-1];
		job.x_min = chwl_pkg::MIN_W'(x_lo_n);
		job.x_max = chwl_pkg::MAX_W'(x_hi_n);
		job.y_min = chwl_pkg::MIN_W'(y_lo_n);
		job.y_max = chwl_pkg::MAX_W'(y_hi_n);
		job.z_min = chwl_pkg::MIN_W'(z_lo_n);
		job.z_max = chwl_pkg::MAX_W'(z_hi_n);
	end

	`CHWL_ASSERT_IMPLY(a_bounds_span_zero, clk, arst_n, 1'b1,
		x_low_q <= 0 && x_high_q >= 0 && y_low_q <= 0 && y_high_q >= 0 &&
		z_low_q <= 0 && z_high_q >= 0, "axis bounds no longer include zero")
	`CHWL_ASSERT_NEXT(a_low_tracks, clk, arst_n, push && xv < x_low_q,
		x_low_q == $past(xv), "x minimum missed a smaller sample")

endmodule

// ----- sv/chwl_queue.sv -----
// Short queue of classified samples between front end and CORDIC engine
`include "compass_heading_with_limits_assert.svh"

module chwl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  chwl_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output chwl_pkg::job_t pop_job,
	output logic           empty
);

	chwl_pkg::job_t entry_q [chwl_pkg::QUEUE_DEPTH];

	logic [chwl_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [chwl_pkg::QUEUE_PTR_W:0]   count_q;

	assign full    = (count_q == (chwl_pkg::QUEUE_PTR_W + 1)'(chwl_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`CHWL_ASSERT_IMPLY(a_no_overflow, clk, arst_n, push, !full,
		"push into a full queue")
	`CHWL_ASSERT_IMPLY(a_no_underflow, clk, arst_n, pop, !empty,
		"pop from an empty queue")
	`CHWL_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop,
		count_q == $past(count_q) + 1'b1, "queue count lost a push")

endmodule

// ----- sv/chwl_cordic.sv -----
// Back end: iterative vectoring CORDIC for the heading, plus the result register
`include "compass_heading_with_limits_assert.svh"

module chwl_cordic #(
	parameter int CORDIC_STEPS = 16,
	parameter int SAMPLE_BITS  = 13
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  chwl_pkg::job_t pop_job,
	output logic           pop,
	chwl_result_if.source  result
);

	localparam int W      = SAMPLE_BITS + chwl_pkg::CORDIC_GUARD;
	localparam int HI_W   = W - chwl_pkg::PRESCALE_SH;
	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RUN  = 4'b0010,
		S_FOLD = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                             state_q;
	logic [STEP_W-1:0]                  step_q;
	logic signed [W-1:0]                x_q, y_q;
	logic signed [chwl_pkg::ANG_W-1:0]  ang_q;
	chwl_pkg::job_t                     job_q;

	logic signed [W-1:0]                x_pre, y_pre, x_sh, y_sh, x_nx, y_nx;
	logic signed [chwl_pkg::ANG_W-1:0]  at, ang_nx, ang_fold;
	logic [chwl_pkg::ANG_W-1:0]         rnd;
	logic [chwl_pkg::HEADING_W:0]       h_raw;
	logic [chwl_pkg::HEADING_W-1:0]     heading_d;
	logic                               can_write;

	logic                               res_valid_q;
	logic [chwl_pkg::HEADING_W-1:0]     heading_q;
	logic signed [chwl_pkg::MIN_W-1:0]  x_min_q, y_min_q, z_min_q;
	logic [chwl_pkg::MAX_W-1:0]         x_max_q, y_max_q, z_max_q;

	assign pop       = (state_q == S_IDLE) && !empty;
	assign can_write = !res_valid_q || result.ready;

	// scale by 2^24 on load
	assign x_pre = {HI_W'(pop_job.x), {chwl_pkg::PRESCALE_SH{1'b0}}};
	assign y_pre = {HI_W'(pop_job.y), {chwl_pkg::PRESCALE_SH{1'b0}}};

	always_comb begin
		x_sh = x_q >>> step_q;
		y_sh = y_q >>> step_q;
		at   = chwl_pkg::ANG_W'(chwl_pkg::ATAN_Q16[chwl_pkg::ATAN_IDX_W'(step_q)]);
		// rotate toward the X axis: clockwise while y is non-negative
		if (!y_q[W-1]) begin
			x_nx   = x_q + y_sh;
			y_nx   = y_q - x_sh;
			ang_nx = ang_q + at;
		end else begin
			x_nx   = x_q - y_sh;
			y_nx   = y_q + x_sh;
			ang_nx = ang_q - at;
		end
		ang_fold = ang_q[chwl_pkg::ANG_W-1] ? ang_q + chwl_pkg::DEG360 : ang_q;
	end

	always_comb begin
		rnd   = ang_q + chwl_pkg::ROUND_HALF;
		h_raw = (chwl_pkg::HEADING_W + 1)'(rnd >> chwl_pkg::ROUND_SH);
		if (h_raw >= chwl_pkg::HEADING_FULL) begin
			heading_d = chwl_pkg::HEADING_W'(h_raw - chwl_pkg::HEADING_FULL);
		end else begin
			heading_d = chwl_pkg::HEADING_W'(h_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && can_write) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						state_q <= S_RUN;
						step_q  <= '0;
					end
				end
				S_RUN: begin
					if (step_q == LAST_STEP) begin
						state_q <= S_FOLD;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_FOLD: state_q <= S_DONE;
				S_DONE: begin
					if (can_write) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= pop_job;
			// pre-rotate the left half plane by 180 degrees
			x_q   <= pop_job.neg ? -x_pre : x_pre;
			y_q   <= pop_job.neg ? -y_pre : y_pre;
			ang_q <= pop_job.neg ? chwl_pkg::DEG180 : '0;
		end else if (state_q == S_RUN) begin
			x_q   <= x_nx;
			y_q   <= y_nx;
			ang_q <= ang_nx;
		end else if (state_q == S_FOLD) begin
			ang_q <= ang_fold;
		end
		if (state_q == S_DONE && can_write) begin
			heading_q <= job_q.zero ? '0 : heading_d;
			x_min_q   <= job_q.x_min;
			x_max_q   <= job_q.x_max;
			y_min_q   <= job_q.y_min;
			y_max_q   <= job_q.y_max;
			z_min_q   <= job_q.z_min;
			z_max_q   <= job_q.z_max;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.heading_q6 = heading_q;
	assign result.x_min_out  = x_min_q;
	assign result.x_max_out  = x_max_q;
	assign result.y_min_out  = y_min_q;
	assign result.y_max_out  = y_max_q;
	assign result.z_min_out  = z_min_q;
	assign result.z_max_out  = z_max_q;

	`CHWL_ASSERT_NEXT(a_load_starts_run, clk, arst_n, pop,
		state_q == S_RUN && step_q == '0, "load did not start the iterations")
	`CHWL_ASSERT_NEXT(a_run_ends, clk, arst_n, state_q == S_RUN && step_q == LAST_STEP,
		state_q == S_FOLD, "iteration count overran")
	`CHWL_ASSERT_IMPLY(a_heading_range, clk, arst_n, res_valid_q,
		{1'b0, heading_q} < chwl_pkg::HEADING_FULL, "heading not below 360 degrees")

endmodule

// ----- sv/compass_heading_with_limits.sv -----
// Compass heading with running axis limits: top level
//
// Channel "sample" (valid/ready) takes one signed X, Y, Z magnetometer reading per
// transaction. Channel "result" (valid/ready) returns one transaction per sample:
// heading_q6 = atan2(Y, X) in degrees times 64, folded to 0..359.98 and rounded,
// with X = Y = 0 giving 0, plus the smallest and largest reading of each axis
// seen so far, zero included, bounds included for the sample just taken.
// A sample is taken while the queue is not full: the front end updates the bounds and
// writes a two-entry queue. The CORDIC engine reads the queue, runs CORDIC_STEPS
// iterations of one shared shift-add unit, folds and rounds the angle, and
// loads the result register; it reads no new sample from the queue until the
// result register has taken the last one.
// Reset clears all six bounds to zero, empties the queue and drops result valid.
// A stalled receiver holds the result register; the engine finishes the next
// sample and waits, and the front end keeps taking samples until the queue fills.

module compass_heading_with_limits #(
	parameter int CORDIC_STEPS = 16,
	parameter int SAMPLE_BITS  = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	chwl_sample_if.sink   sample,
	chwl_result_if.source result
);

	logic           push, full, pop, empty;
	chwl_pkg::job_t push_job, pop_job;

	chwl_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.full   (full),
		.push   (push),
		.job    (push_job)
	);

	chwl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (empty)
	);

	chwl_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.pop_job (pop_job),
		.pop     (pop),
		.result  (result)
	);

endmodule

// ----- sim/compass_heading_with_limits_check.sv -----
// Checker for the compass heading block: predicts heading and axis bounds, compares results
module compass_heading_with_limits_check (
	input  logic   clk,
	input  logic   arst_n,
	chwl_sample_if sample,
	chwl_result_if result,
	output int     errors,
	output int     pending,
	output int     checked,
	output int     origin_hits,
	output int     wraps
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STEPS = 16;
	localparam longint SCALE = 64'sd16777216;
	localparam longint HALF_TURN = 64'sd180 * 64'sd65536;
	localparam longint FULL_TURN = 64'sd360 * 64'sd65536;
	localparam longint FULL_HEADING = 64'sd23040;

	// atan(2^-i) in degrees times 2^16
	localparam longint ARCTAN_DEG [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef struct {
		logic        [14:0] heading;
		logic signed [12:0] x_min;
		logic        [11:0] x_max;
		logic signed [12:0] y_min;
		logic        [11:0] y_max;
		logic signed [12:0] z_min;
		logic        [11:0] z_max;
	} heading_bounds_t;

	heading_bounds_t headings_due[$];
	heading_bounds_t want;
	heading_bounds_t got;
	int x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
	int xs, ys, zs;
	bit wrapped;

	initial begin
		errors = 0;
		checked = 0;
		origin_hits = 0;
		wraps = 0;
	end

	// vectoring CORDIC on samples scaled by 2^24, angle in degrees times 2^16
	function automatic logic [14:0] cordic_heading(input int xv, input int yv, output bit wrap);
		longint x, y, nx, ny, ang, h;
		wrap = 0;
		if (xv == 0 && yv == 0)
			return '0;
		x = longint'(xv) * SCALE;
		y = longint'(yv) * SCALE;
		ang = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			ang = HALF_TURN;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				ang += ARCTAN_DEG[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				ang -= ARCTAN_DEG[i];
			end
			x = nx;
			y = ny;
		end
		if (ang < 0)
			ang += FULL_TURN;
		h = (ang + 64'sd512) >>> 10;
		if (h >= FULL_HEADING) begin
			h -= FULL_HEADING;
			wrap = 1;
		end
		return h[14:0];
	endfunction

	function automatic void check_field(input string name, input logic signed [15:0] exp_v,
			input logic signed [15:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			headings_due.delete();
			x_lo = 0; x_hi = 0;
			y_lo = 0; y_hi = 0;
			z_lo = 0; z_hi = 0;
			pending <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (headings_due.size() == 0) begin
					$error("result transaction with no sample pending");
					errors++;
				end else begin
					want = headings_due.pop_front();
					got.heading = result.heading_q6;
					got.x_min = result.x_min_out;
					got.x_max = result.x_max_out;
					got.y_min = result.y_min_out;
					got.y_max = result.y_max_out;
					got.z_min = result.z_min_out;
					got.z_max = result.z_max_out;
					check_field("heading_q6", want.heading, got.heading);
					check_field("x_min_out", want.x_min, got.x_min);
					check_field("x_max_out", want.x_max, got.x_max);
					check_field("y_min_out", want.y_min, got.y_min);
					check_field("y_max_out", want.y_max, got.y_max);
					check_field("z_min_out", want.z_min, got.z_min);
					check_field("z_max_out", want.z_max, got.z_max);
					checked++;
				end
			end
			if (sample.valid && sample.ready) begin
				xs = sample.x_sample;
				ys = sample.y_sample;
				zs = sample.z_sample;
				if (xs < x_lo) x_lo = xs;
				if (xs > x_hi) x_hi = xs;
				if (ys < y_lo) y_lo = ys;
				if (ys > y_hi) y_hi = ys;
				if (zs < z_lo) z_lo = zs;
				if (zs > z_hi) z_hi = zs;
				want.heading = cordic_heading(xs, ys, wrapped);
				want.x_min = 13'(x_lo);
				want.x_max = 12'(x_hi);
				want.y_min = 13'(y_lo);
				want.y_max = 12'(y_hi);
				want.z_min = 13'(z_lo);
				want.z_max = 12'(z_hi);
				headings_due.push_back(want);
				if (xs == 0 && ys == 0)
					origin_hits++;
				if (wrapped)
					wraps++;
			end
			pending <= headings_due.size();
		end
	end

endmodule

// ----- sim/compass_heading_with_limits_test.sv -----
// Testbench top for the compass heading block: stimulus, receiver stalls and verdict
module compass_heading_with_limits_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_SAMPLES = 1850;
	localparam int HOLD_AT = 500;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n;
	int cycles = 0;
	int sent = 0;
	int taken = 0;
	bit calm = 0;
	int errors, pending, checked, origin_hits, wraps;

	chwl_sample_if #(.SAMPLE_BITS(13)) sample_ch ();
	chwl_result_if result_ch ();

	compass_heading_with_limits #(
		.CORDIC_STEPS(16),
		.SAMPLE_BITS(13)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch.sink),
		.result(result_ch.source)
	);

	compass_heading_with_limits_check checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch),
		.errors(errors),
		.pending(pending),
		.checked(checked),
		.origin_hits(origin_hits),
		.wraps(wraps)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// full range when span is 0, else -span..span
	function automatic logic signed [12:0] pick(input int span);
		if (span == 0)
			return 13'($urandom);
		return 13'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	task automatic offer(input logic signed [12:0] x, input logic signed [12:0] y,
			input logic signed [12:0] z);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.x_sample <= x;
		sample_ch.y_sample <= y;
		sample_ch.z_sample <= z;
		do @(posedge clk); while (!sample_ch.ready);
		sent++;
	endtask

	// receiver: random stalls, one long hold-off to back the block up
	initial begin
		int stall;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 5);
			if (taken == HOLD_AT)
				stall = HOLD_CYCLES;
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			taken++;
		end
	end

	initial begin
		int mix;
		logic signed [12:0] x, y, z;
		arst_n = 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.x_sample <= '0;
		sample_ch.y_sample <= '0;
		sample_ch.z_sample <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bounds grow step by step, full-scale extremes toward the end
		offer(0, 0, 0);
		offer(1, 0, -1);
		offer(0, 1, 2);
		offer(-1, 0, 3);
		offer(0, -1, -4);
		offer(3, 3, -3);
		offer(-5, 5, 7);
		offer(-7, -7, -9);
		offer(9, -9, 11);
		offer(100, 0, 0);
		offer(-100, 0, 0);
		offer(0, -200, 50);
		offer(1000, -1, -60);
		offer(-1, -1000, 0);
		offer(2047, 2048, 0);
		offer(4095, 0, 4095);
		offer(-4096, 0, -4096);
		offer(0, 4095, 0);
		offer(0, -4096, 0);
		offer(4095, 4095, -1);
		offer(-4096, -4096, 1);
		offer(-4096, 4095, 0);
		offer(4095, -4096, 0);
		offer(-1, 1, 0);

		for (int n = 0; n < RANDOM_SAMPLES; n++) begin
			calm = ((n / 150) % 5) == 4;
			mix = $urandom_range(0, 9);
			z = pick(0);
			case (mix)
				5, 6: begin
					x = pick(8);
					y = pick(8);
					z = pick(8);
				end
				7: begin
					x = $urandom_range(0, 1) ? pick(0) : 13'sd0;
					y = (x == 0) ? pick(0) : 13'sd0;
				end
				// near the positive X axis the heading may round up to a full turn
				8: begin
					x = 13'($urandom_range(1, 4095));
					y = pick(1);
				end
				9: begin
					x = pick(0);
					y = pick(3);
				end
				default: begin
					x = pick(0);
					y = pick(0);
				end
			endcase
			offer(x, y, z);
		end
		calm = 0;
		sample_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d samples sent, %0d results checked: %0d at the origin, %0d headings wrapped to 0",
			sent, checked, origin_hits, wraps);
		$display("receiver held off %0d cycles once to fill the block and stall its input",
			HOLD_CYCLES);
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
